// ===== design/tiffhdp_pkg.sv =====
// ----------------------------------------------------------------------------
// tiffhdp_pkg
// Shared types, codes and byte-assembly helpers for the TIFF header
// dimension parser.
// ----------------------------------------------------------------------------
package tiffhdp_pkg;

  // Width of the saturating file position counter
  localparam int POS_BITS = 32;

  // TIFF codes
  localparam logic [15:0] TAG_WIDTH   = 16'h0100;
  localparam logic [15:0] TAG_HEIGHT  = 16'h0101;
  localparam logic [15:0] TYPE_SHORT  = 16'h0003;
  localparam logic [15:0] TYPE_LONG   = 16'h0004;
  localparam logic [7:0]  ORDER_INTEL = 8'h49;

  // Entry layout: last byte of a 12-byte directory entry
  localparam logic [3:0]  ENTRY_LAST  = 4'd11;

  // Parser phases, one-hot
  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_SKIP   = 5'b00010,
    PH_COUNT  = 5'b00100,
    PH_ENTRY  = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_OFFSET  = 2'd1,
    ST_TAG_MISSING = 2'd2,
    ST_TRUNCATED   = 2'd3
  } status_t;

  // One result item
  typedef struct packed {
    status_t     status;
    logic [31:0] image_width;
    logic [31:0] image_height;
  } res_t;

  // Insert byte k of a 32-bit field in the selected byte order
  function automatic logic [31:0] take32(input logic [31:0] acc, input logic [7:0] b,
                                         input logic [1:0] k, input logic le);
    logic [31:0] r;
    if (le) begin
      r = acc | ({24'd0, b} << {k, 3'b000});
    end else begin
      r = {acc[23:0], b};
    end
    return r;
  endfunction

  // Insert byte k of a 16-bit field in the selected byte order
  function automatic logic [15:0] take16(input logic [15:0] acc, input logic [7:0] b,
                                         input logic k, input logic le);
    logic [15:0] r;
    if (le) begin
      r = acc | ({8'd0, b} << {k, 3'b000});
    end else begin
      r = {acc[7:0], b};
    end
    return r;
  endfunction

endpackage

// ===== design/tiffhdp_parser.sv =====
// ----------------------------------------------------------------------------
// tiffhdp_parser
// Parser state and the single-pass next-state logic: one file byte per
// step, result flagged in the same cycle as the byte that settles the file.
// ----------------------------------------------------------------------------
module tiffhdp_parser
  import tiffhdp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,        // a byte is processed this cycle
  input  logic [7:0] file_byte,
  input  logic       end_of_file,
  output logic       res_valid,
  output res_t       res
);

  // State registers
  phase_t                phase_r,  phase_nxt;
  logic [POS_BITS-1:0]   pos_r,    pos_nxt;
  logic                  le_r,     le_nxt;
  logic [31:0]           off_r,    off_nxt;
  logic [15:0]           total_r,  total_nxt;
  logic [15:0]           done_r,   done_nxt;
  logic [3:0]            idx_r,    idx_nxt;
  logic [15:0]           tag_r,    tag_nxt;
  logic [15:0]           type_r,   type_nxt;
  logic [31:0]           val_r,    val_nxt;
  logic                  wfound_r, wfound_nxt;
  logic                  hfound_r, hfound_nxt;
  logic [31:0]           wval_r,   wval_nxt;
  logic [31:0]           hval_r,   hval_nxt;

  // Next-state and result logic
  always_comb begin
    logic [15:0] half;
    logic [3:0]  i;
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    le_nxt     = le_r;
    off_nxt    = off_r;
    total_nxt  = total_r;
    done_nxt   = done_r;
    idx_nxt    = idx_r;
    tag_nxt    = tag_r;
    type_nxt   = type_r;
    val_nxt    = val_r;
    wfound_nxt = wfound_r;
    hfound_nxt = hfound_r;
    wval_nxt   = wval_r;
    hval_nxt   = hval_r;
    res_valid  = 1'b0;
    res.status = ST_OK;
    i          = idx_r;
    half       = 16'd0;

    if (phase_r == PH_HEADER) begin
      // byte order, then directory offset in bytes 4 to 7
      if (pos_r == '0) begin
        le_nxt = (file_byte == ORDER_INTEL);
      end
      if (pos_r >= POS_BITS'(4) && pos_r <= POS_BITS'(7)) begin
        off_nxt = take32(off_r, file_byte, pos_r[1:0], le_nxt);
      end
      if (pos_r >= POS_BITS'(7)) begin
        if (off_nxt < 32'd8) begin
          res_valid  = 1'b1;
          res.status = ST_BAD_OFFSET;
          phase_nxt  = PH_DONE;
        end else begin
          phase_nxt = PH_SKIP;
        end
      end
    end else begin
      // reaching the directory: this byte is the first count byte
      if (phase_r == PH_SKIP && 32'(pos_r) == off_r) begin
        phase_nxt = PH_COUNT;
        idx_nxt   = 4'd0;
        total_nxt = 16'd0;
      end
      if (phase_nxt == PH_COUNT) begin
        total_nxt = take16(total_nxt, file_byte, idx_nxt[0], le_r);
        idx_nxt   = idx_nxt + 4'd1;
        if (idx_nxt >= 4'd2) begin
          phase_nxt = PH_ENTRY;
          idx_nxt   = 4'd0;
          done_nxt  = 16'd0;
        end
      end else if (phase_nxt == PH_ENTRY) begin
        // entry fields: tag, type, skipped count, value
        if (i < 4'd2) begin
          tag_nxt = take16((i == 4'd0) ? 16'd0 : tag_r, file_byte, i[0], le_r);
        end else if (i < 4'd4) begin
          type_nxt = take16((i == 4'd2) ? 16'd0 : type_r, file_byte, i[0], le_r);
        end else if (i >= 4'd8) begin
          val_nxt = take32((i == 4'd8) ? 32'd0 : val_r, file_byte, i[1:0], le_r);
        end
        if (i >= ENTRY_LAST) begin
          idx_nxt = 4'd0;
          half    = le_r ? val_nxt[15:0] : val_nxt[31:16];
          if (tag_r == TAG_WIDTH) begin
            wfound_nxt = 1'b1;
            if (type_r == TYPE_SHORT) begin
              wval_nxt = {16'd0, half};
            end else if (type_r == TYPE_LONG) begin
              wval_nxt = val_nxt;
            end
          end else if (tag_r == TAG_HEIGHT) begin
            hfound_nxt = 1'b1;
            if (type_r == TYPE_SHORT) begin
              hval_nxt = {16'd0, half};
            end else if (type_r == TYPE_LONG) begin
              hval_nxt = val_nxt;
            end
          end
          done_nxt = done_r + 16'd1;
          if (wfound_nxt && hfound_nxt) begin
            res_valid  = 1'b1;
            res.status = ST_OK;
            phase_nxt  = PH_DONE;
          end else if (done_nxt >= total_r) begin
            res_valid  = 1'b1;
            res.status = ST_TAG_MISSING;
            phase_nxt  = PH_DONE;
          end
        end else begin
          idx_nxt = i + 4'd1;
        end
      end
    end

    // saturating position
    if (pos_r != {POS_BITS{1'b1}}) begin
      pos_nxt = pos_r + POS_BITS'(1);
    end

    // end of file: truncation if undecided, then rearm
    if (end_of_file) begin
      if (phase_nxt != PH_DONE) begin
        res_valid  = 1'b1;
        res.status = ST_TRUNCATED;
      end
      phase_nxt  = PH_HEADER;
      pos_nxt    = '0;
      le_nxt     = 1'b0;
      off_nxt    = 32'd0;
      total_nxt  = 16'd0;
      done_nxt   = 16'd0;
      idx_nxt    = 4'd0;
      tag_nxt    = 16'd0;
      type_nxt   = 16'd0;
      val_nxt    = 32'd0;
      wfound_nxt = 1'b0;
      hfound_nxt = 1'b0;
    end

    res.image_width  = (res.status == ST_OK) ? wval_nxt : 32'd0;
    res.image_height = (res.status == ST_OK) ? hval_nxt : 32'd0;

    if (end_of_file) begin
      wval_nxt = 32'd0;
      hval_nxt = 32'd0;
    end
  end

  // State update on each processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      pos_r    <= '0;
      le_r     <= 1'b0;
      off_r    <= 32'd0;
      total_r  <= 16'd0;
      done_r   <= 16'd0;
      idx_r    <= 4'd0;
      tag_r    <= 16'd0;
      type_r   <= 16'd0;
      val_r    <= 32'd0;
      wfound_r <= 1'b0;
      hfound_r <= 1'b0;
      wval_r   <= 32'd0;
      hval_r   <= 32'd0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      le_r     <= le_nxt;
      off_r    <= off_nxt;
      total_r  <= total_nxt;
      done_r   <= done_nxt;
      idx_r    <= idx_nxt;
      tag_r    <= tag_nxt;
      type_r   <= type_nxt;
      val_r    <= val_nxt;
      wfound_r <= wfound_nxt;
      hfound_r <= hfound_nxt;
      wval_r   <= wval_nxt;
      hval_r   <= hval_nxt;
    end
  end

`ifndef SYNTHESIS
  // end of file always rearms the parser
  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    step && end_of_file |=> phase_r == PH_HEADER && pos_r == '0)
    else $error("parser not rearmed after end of file");

  // a decided file gives no further results
  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE && !end_of_file |-> !res_valid)
    else $error("result after decision");

  // entry byte index stays within an entry
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ENTRY |-> idx_r <= ENTRY_LAST)
    else $error("entry byte index out of range");
`endif

endmodule

// ===== design/tiff_header_dimension_parser_unit.sv =====
// Timing: a result is captured in the output register as its deciding byte is
// taken from the input register, which holds each byte after acceptance.
// Throughput: one byte per cycle unless output stalls; at most one result per file.
// Reset: synchronous, active low; clears parser state and both stage valid flags.
// After the last byte of a file the parser returns to its reset state.
// ----------------------------------------------------------------------------
// tiff_header_dimension_parser_unit
// Top level: input register, parser, output register with stream handshakes.
// ----------------------------------------------------------------------------
module tiff_header_dimension_parser_unit
  import tiffhdp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] file_byte
  input  logic        in_tlast,   // end_of_file
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // [1:0] status, [33:2] image_width,
                                  // [65:34] image_height, [71:66] zero
);

  logic       stage_valid_r;
  logic [7:0] stage_byte_r;
  logic       stage_eof_r;
  logic       out_valid_r;
  res_t       out_res_r;
  logic       advance;
  logic       res_valid;
  res_t       res;

  // Stage moves on when the output register is free or draining
  assign advance   = stage_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !stage_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      stage_valid_r <= 1'b1;
    end else if (advance) begin
      stage_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      stage_byte_r <= in_tdata;
      stage_eof_r  <= in_tlast;
    end
  end

  tiffhdp_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .file_byte   (stage_byte_r),
    .end_of_file (stage_eof_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.image_height, out_res_r.image_width,
                       out_res_r.status};

`ifndef SYNTHESIS
  // input stalls only when the output is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> stage_valid_r && out_valid_r && !out_tready)
    else $error("input stalled without output back-pressure");

  // failed status carries zero dimensions
  a_zero_dims: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.status != ST_OK |->
      out_res_r.image_width == 32'd0 && out_res_r.image_height == 32'd0)
    else $error("nonzero dimensions with failed status");

  // a produced result is always captured
  a_capture: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res_valid |=> out_valid_r)
    else $error("result lost");
`endif

endmodule

// ===== tb/tiffhdp_dim_checker.sv =====
// ----------------------------------------------------------------------------
// tiffhdp_dim_checker
// Watches both stream channels of the TIFF dimension parser, predicts the
// one result per file from the accepted bytes and compares each result
// transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tiffhdp_dim_checker
  import tiffhdp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] file_byte
  input  logic        in_tlast,     // end_of_file
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,    // [1:0] status, [33:2] image_width,
                                    // [65:34] image_height, [71:66] zero
  input  logic        drain_done,
  output int          dims_pending,
  output int          mismatch_count
);

  timeunit 1ns;
  timeprecision 1ps;

  // Predicted results still waiting for their transfer
  res_t expected_dims[$];
  bit   leftovers_checked;

  // Shadow parser state
  phase_t              ph;
  logic [POS_BITS-1:0] file_pos;
  logic                order_le;
  logic [31:0]         dir_offset;
  logic [15:0]         entry_count;
  logic [15:0]         entries_seen;
  logic [3:0]          entry_idx;
  logic [15:0]         entry_tag;
  logic [15:0]         entry_kind;
  logic [31:0]         entry_value;
  logic                width_seen;
  logic                height_seen;
  logic [31:0]         width_word;
  logic [31:0]         height_word;
  logic                settled;

  initial begin
    dims_pending   = 0;
    mismatch_count = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] dimension check: %s", $time, msg);
    mismatch_count++;
  endtask

  // Add one byte of a multi-byte field in the file's byte order
  function automatic logic [31:0] merge_byte(input logic [31:0] acc, input logic [7:0] b,
                                             input int unsigned k, input logic le);
    logic [31:0] merged;
    if (le) begin
      merged = acc | (32'(b) << (8 * (k % 4)));
    end else begin
      merged = {acc[23:0], b};
    end
    return merged;
  endfunction

  task automatic clear_parser();
    ph           = PH_HEADER;
    file_pos     = '0;
    order_le     = 1'b0;
    dir_offset   = '0;
    entry_count  = '0;
    entries_seen = '0;
    entry_idx    = '0;
    entry_tag    = '0;
    entry_kind   = '0;
    entry_value  = '0;
    width_seen   = 1'b0;
    height_seen  = 1'b0;
    width_word   = '0;
    height_word  = '0;
    settled      = 1'b0;
  endtask

  // File decided: queue its result, dimensions only on success
  task automatic settle(input status_t st);
    res_t r;
    r.status       = st;
    r.image_width  = (st == ST_OK) ? width_word  : 32'd0;
    r.image_height = (st == ST_OK) ? height_word : 32'd0;
    expected_dims.push_back(r);
    settled = 1'b1;
    ph      = PH_DONE;
  endtask

  // Last byte of a directory entry: apply width or height
  task automatic close_entry();
    logic [31:0] half;
    half = order_le ? {16'd0, entry_value[15:0]} : {16'd0, entry_value[31:16]};
    if (entry_tag == TAG_WIDTH) begin
      width_seen = 1'b1;
      if (entry_kind == TYPE_SHORT) width_word = half;
      else if (entry_kind == TYPE_LONG) width_word = entry_value;
    end else if (entry_tag == TAG_HEIGHT) begin
      height_seen = 1'b1;
      if (entry_kind == TYPE_SHORT) height_word = half;
      else if (entry_kind == TYPE_LONG) height_word = entry_value;
    end
    entries_seen++;
  endtask

  // Predictor: one accepted file byte
  task automatic parse_file_byte(input logic [7:0] b, input logic eof);
    logic [POS_BITS-1:0] p;
    int unsigned         i;
    p = file_pos;
    if (ph == PH_HEADER) begin
      if (p == 0) order_le = (b == ORDER_INTEL);
      if (p >= 4 && p <= 7) dir_offset = merge_byte(dir_offset, b, p - 4, order_le);
      if (p >= 7) begin
        if (dir_offset < 8) settle(ST_BAD_OFFSET);
        else ph = PH_SKIP;
      end
    end else begin
      if (ph == PH_SKIP && 32'(p) == dir_offset) begin
        ph          = PH_COUNT;
        entry_idx   = '0;
        entry_count = '0;
      end
      if (ph == PH_COUNT) begin
        entry_count = 16'(merge_byte({16'd0, entry_count}, b, entry_idx, order_le));
        entry_idx++;
        if (entry_idx >= 2) begin
          ph           = PH_ENTRY;
          entry_idx    = '0;
          entries_seen = '0;
        end
      end else if (ph == PH_ENTRY) begin
        i = entry_idx;
        if (i == 0) entry_tag = '0;
        if (i == 2) entry_kind = '0;
        if (i == 8) entry_value = '0;
        if (i < 2) entry_tag = 16'(merge_byte({16'd0, entry_tag}, b, i, order_le));
        else if (i < 4) entry_kind = 16'(merge_byte({16'd0, entry_kind}, b, i - 2, order_le));
        else if (i >= 8) entry_value = merge_byte(entry_value, b, i - 8, order_le);
        if (i >= 11) begin
          entry_idx = '0;
          close_entry();
          if (width_seen && height_seen) settle(ST_OK);
          else if (entries_seen >= entry_count) settle(ST_TAG_MISSING);
        end else begin
          entry_idx = 4'(i + 1);
        end
      end
    end
    // position counter saturates
    if (file_pos != '1) file_pos++;
    // last byte: truncation if undecided, then rearm
    if (eof) begin
      if (!settled) settle(ST_TRUNCATED);
      clear_parser();
    end
  endtask

  // Sample both channels at each edge
  always @(posedge clk) begin
    res_t exp_dims;
    if (!rst_n) begin
      clear_parser();
      expected_dims.delete();
    end else begin
      if (in_tvalid && in_tready) parse_file_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (expected_dims.size() == 0) begin
          report_mismatch($sformatf("result transfer with nothing expected, data %h",
                                    out_tdata));
        end else begin
          exp_dims = expected_dims.pop_front();
          if (out_tdata[1:0] != exp_dims.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_tdata[1:0],
                                      exp_dims.status));
          if (out_tdata[33:2] != exp_dims.image_width)
            report_mismatch($sformatf("width %h, expected %h", out_tdata[33:2],
                                      exp_dims.image_width));
          if (out_tdata[65:34] != exp_dims.image_height)
            report_mismatch($sformatf("height %h, expected %h", out_tdata[65:34],
                                      exp_dims.image_height));
          if (out_tdata[71:66] != '0)
            report_mismatch($sformatf("padding bits %b not zero", out_tdata[71:66]));
        end
      end
      if (drain_done && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (expected_dims.size() != 0)
          report_mismatch($sformatf("%0d expected results never arrived",
                                    expected_dims.size()));
      end
    end
    dims_pending <= expected_dims.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the TIFF header dimension parser: directed files
// for byte order, offsets, entry types and early ends, then random files,
// mostly well formed, with random gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
module tb_top;
  import tiffhdp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RANDOM_BYTES   = 760;
  localparam int          RANDOM_FILES   = 12;
  localparam int          WATCHDOG_LIMIT = 1000;
  localparam logic [7:0]  ORDER_MOTOROLA = 8'h4D;
  localparam logic [15:0] TIFF_MAGIC     = 16'd42;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;    // [7:0] file_byte
  logic        in_tlast   = 1'b0;  // end_of_file
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;          // [1:0] status, [33:2] image_width,
                                   // [65:34] image_height, [71:66] zero
  logic        drain_done = 1'b0;
  int          dims_pending;
  int          mismatch_count;

  // File under construction
  logic [7:0] file_bytes[$];
  bit         file_le;
  bit         calm;
  int         bytes_sent;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  tiff_header_dimension_parser_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  tiffhdp_dim_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .drain_done     (drain_done),
    .dims_pending   (dims_pending),
    .mismatch_count (mismatch_count)
  );

  // File builders, multi-byte fields in the file's byte order
  task automatic put16(input logic [15:0] v);
    if (file_le) begin
      file_bytes.push_back(v[7:0]);
      file_bytes.push_back(v[15:8]);
    end else begin
      file_bytes.push_back(v[15:8]);
      file_bytes.push_back(v[7:0]);
    end
  endtask

  task automatic put32(input logic [31:0] v);
    if (file_le) begin
      put16(v[15:0]);
      put16(v[31:16]);
    end else begin
      put16(v[31:16]);
      put16(v[15:0]);
    end
  endtask

  task automatic add_noise(input int n);
    repeat (n) file_bytes.push_back(8'($urandom));
  endtask

  // Header, then filler up to a reachable directory offset
  task automatic start_file(input bit le, input logic [31:0] offset);
    logic [7:0] order;
    file_bytes.delete();
    file_le = le;
    order   = le ? ORDER_INTEL : ($urandom_range(0, 1) ? ORDER_MOTOROLA : 8'($urandom));
    if (!le && order == ORDER_INTEL) order = ORDER_MOTOROLA;
    file_bytes.push_back(order);
    file_bytes.push_back(order);
    put16($urandom_range(0, 3) != 0 ? TIFF_MAGIC : 16'($urandom));
    put32(offset);
    if (offset >= 8 && offset < 64)
      while (file_bytes.size() < offset) file_bytes.push_back(8'($urandom));
  endtask

  task automatic put_entry(input logic [15:0] tag, input logic [15:0] kind,
                           input logic [31:0] value);
    put16(tag);
    put16(kind);
    put32($urandom);
    put32(value);
  endtask

  function automatic logic [15:0] pick_tag();
    case ($urandom_range(0, 5))
      0, 1:    return TAG_WIDTH;
      2, 3:    return TAG_HEIGHT;
      4:       return TAG_WIDTH ^ (16'd1 << $urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_kind();
    case ($urandom_range(0, 4))
      0, 2:    return TYPE_SHORT;
      1, 3:    return TYPE_LONG;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // One byte transfer after a random gap
  task automatic send_byte(input logic [7:0] b, input logic eof);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eof;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic send_file();
    calm = ($urandom_range(0, 3) == 0);
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  // Directory at a valid offset with random entries and a random entry count
  task automatic build_random_tiff();
    start_file(1'($urandom_range(0, 1)), 8 + $urandom_range(0, 6));
    put16($urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 6)));
    repeat ($urandom_range(1, 6)) put_entry(pick_tag(), pick_kind(), pick_word());
    add_noise($urandom_range(0, 4));
  endtask

  // Result side: random stall before each result transfer
  initial begin
    int stall;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Watchdog on cycles without any transfer
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("** tiff_header_dimension_parser_unit: FAILED **");
    $finish;
  end

  // Main sequence
  initial begin
    int random_start;
    int random_files;
    int len;
    int drain_cycles;
    bytes_sent   = 0;
    random_files = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // both byte orders, dimension extremes
    start_file(1'b1, 32'd8);
    put16(16'd2);
    put_entry(TAG_WIDTH, TYPE_SHORT, 32'h0000_FFFF);
    put_entry(TAG_HEIGHT, TYPE_LONG, 32'hFFFF_FFFF);
    send_file();
    start_file(1'b0, 32'd8);
    put16(16'd2);
    put_entry(TAG_HEIGHT, TYPE_SHORT, 32'hFFFF_0000);
    put_entry(TAG_WIDTH, TYPE_LONG, 32'd0);
    send_file();

    // offsets below 4 and into the header, trailing bytes ignored
    start_file(1'b1, 32'd0);
    add_noise(4);
    send_file();
    start_file(1'b0, 32'd5);
    add_noise(3);
    send_file();
    // bad offset decided on the last byte
    start_file(1'b1, 32'd7);
    send_file();

    // empty directory still examines one entry
    start_file(1'b1, 32'd8);
    put16(16'd0);
    put_entry(TAG_WIDTH, TYPE_LONG, 32'h0000_1234);
    add_noise(2);
    send_file();

    // unknown type marks the tag found but keeps the value
    start_file(1'b0, 32'd10);
    put16(16'd3);
    put_entry(TAG_WIDTH, 16'h0005, $urandom);
    put_entry(TAG_HEIGHT, TYPE_SHORT, $urandom);
    send_file();

    // width given three times, walk stops once both are found
    start_file(1'b1, 32'd9);
    put16(16'd6);
    put_entry(TAG_WIDTH, TYPE_SHORT, $urandom);
    put_entry(TAG_WIDTH, TYPE_LONG, 32'h8000_0001);
    put_entry(TAG_HEIGHT, TYPE_LONG, 32'd1);
    put_entry(TAG_WIDTH, TYPE_LONG, 32'd7);
    add_noise(5);
    send_file();

    // directory without either dimension tag
    start_file(1'b0, 32'd8);
    put16(16'd3);
    put_entry(16'h0102, TYPE_SHORT, 32'd8);
    put_entry(16'h0103, TYPE_SHORT, 32'd1);
    put_entry(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_file();

    // file ends inside an entry
    start_file(1'b1, 32'd8);
    put16(16'd2);
    put_entry(TAG_WIDTH, TYPE_SHORT, 32'd640);
    put16(TAG_HEIGHT);
    put16(TYPE_SHORT);
    send_file();

    // one-byte file and a file ending inside the header
    file_bytes.delete();
    file_bytes.push_back(ORDER_INTEL);
    send_file();
    start_file(1'b0, 32'd16);
    file_bytes = file_bytes[0:5];
    send_file();

    // directory offset beyond any reachable position
    start_file(1'b0, 32'hFFFF_FFF0);
    add_noise(6);
    send_file();

    // end of file on the deciding byte, all-ones entry count
    start_file(1'b0, 32'd8);
    put16(16'hFFFF);
    put_entry(TAG_HEIGHT, TYPE_LONG, 32'd0);
    put_entry(TAG_WIDTH, TYPE_LONG, 32'hFFFF_FFFF);
    send_file();
    start_file(1'b1, 32'd8);
    put16(16'd2);
    put_entry(TAG_WIDTH, TYPE_SHORT, 32'd1920);
    put_entry(TAG_HEIGHT, TYPE_SHORT, 32'd1080);
    send_file();

    // random files: mostly well formed, some cut short, bad offsets, noise
    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES || random_files < RANDOM_FILES) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: build_random_tiff();
        6, 7: begin
          build_random_tiff();
          len        = $urandom_range(1, file_bytes.size());
          file_bytes = file_bytes[0:len-1];
        end
        8: begin
          start_file(1'($urandom_range(0, 1)), $urandom_range(0, 7));
          add_noise($urandom_range(0, 8));
        end
        default: begin
          file_bytes.delete();
          add_noise($urandom_range(1, 30));
        end
      endcase
      send_file();
      random_files++;
    end
    in_tvalid <= 1'b0;

    // drain outstanding results, then allow for stray ones
    drain_cycles = 0;
    do begin
      @(posedge clk);
      drain_cycles++;
    end while (dims_pending != 0 && drain_cycles < 300);
    repeat (8) @(posedge clk);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("** tiff_header_dimension_parser_unit: PASSED **");
    end else begin
      $display("** tiff_header_dimension_parser_unit: FAILED **");
    end
    $finish;
  end

endmodule
